@@ rtl/smc_pkg.sv @@
// ----------------------------------------------------------------------------
// smc_pkg
// Types, codes and timing constants of the sumo maneuver controller.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int POSITION_BITS = 11;
  localparam int SPEED_BITS    = 8;
  localparam int GAIN_BITS     = 8;
  localparam int TIME_BITS     = 32;

  // PD datapath widths
  localparam int DIFF_BITS = POSITION_BITS + 1;
  localparam int ACC_BITS  = POSITION_BITS + GAIN_BITS + 3;
  localparam int FRAC_BITS = 4;
  localparam int PID_BITS  = ACC_BITS - FRAC_BITS;
  localparam int SUM_BITS  = PID_BITS + 1;

  localparam int SPEED_MAX = 100;

  localparam logic signed [SPEED_BITS-1:0] SPEED_FULL = 8'sd100;
  localparam logic signed [SPEED_BITS-1:0] SPEED_HALF = 8'sd50;
  localparam logic signed [SPEED_BITS-1:0] SPEED_ZERO = 8'sd0;

  localparam logic [TIME_BITS-1:0] TURN_RIGHT_MS = 32'd100;
  localparam logic [TIME_BITS-1:0] TURN_LEFT_MS  = 32'd125;
  localparam logic [TIME_BITS-1:0] TURN_BACK_MS  = 32'd180;
  localparam logic [TIME_BITS-1:0] REVERSE_MS    = 32'd180;
  localparam logic [TIME_BITS-1:0] SPIN_END_MS   = 32'd340;
  localparam logic [TIME_BITS-1:0] FOLLOW_MS     = 32'd20;
  localparam logic [TIME_BITS-1:0] STEP_ON_MS    = 32'd3000;
  localparam logic [TIME_BITS-1:0] STEP_OFF_MS   = 32'd50;

  // configuration register indexes
  localparam logic [1:0] REG_STRATEGY = 2'd0;
  localparam logic [1:0] REG_OPENING  = 2'd1;
  localparam logic [1:0] REG_PROP     = 2'd2;
  localparam logic [1:0] REG_DERIV    = 2'd3;

  // strategy codes
  localparam logic [1:0] STRAT_STILL  = 2'd0;
  localparam logic [1:0] STRAT_FOLLOW = 2'd1;
  localparam logic [1:0] STRAT_STEPS  = 2'd2;

  // opening codes
  localparam logic [2:0] OPEN_FRONT = 3'd0;
  localparam logic [2:0] OPEN_RIGHT = 3'd1;
  localparam logic [2:0] OPEN_LEFT  = 3'd2;
  localparam logic [2:0] OPEN_BACK  = 3'd3;

  typedef enum logic [1:0] {
    MODE_OPENING = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_KEEPING = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]           strategy;
    logic [2:0]           opening_move;
    logic [GAIN_BITS-1:0] prop_gain;
    logic [GAIN_BITS-1:0] deriv_gain;
  } cfg_t;

  typedef struct packed {
    logic                            started;
    logic                            line_left;
    logic                            line_right;
    logic signed [POSITION_BITS-1:0] target_position;
  } item_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] left_speed;
    logic signed [SPEED_BITS-1:0] right_speed;
    mode_t                        mode;
    logic                         fatal_error;
  } result_t;

endpackage

@@ rtl/smc_pd.sv @@
// ----------------------------------------------------------------------------
// smc_pd
// PD steering: gains times position and position change, scaled, saturated.
// ----------------------------------------------------------------------------
module smc_pd (
  input  logic signed [smc_pkg::POSITION_BITS-1:0] position,
  input  logic signed [smc_pkg::POSITION_BITS-1:0] last_position,
  input  logic        [smc_pkg::GAIN_BITS-1:0]     prop_gain,
  input  logic        [smc_pkg::GAIN_BITS-1:0]     deriv_gain,
  output logic signed [smc_pkg::SPEED_BITS-1:0]    left_speed,
  output logic signed [smc_pkg::SPEED_BITS-1:0]    right_speed
);
  import smc_pkg::*;

  logic signed [DIFF_BITS-1:0] diff;
  logic signed [ACC_BITS-1:0]  prod_p;
  logic signed [ACC_BITS-1:0]  prod_d;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  acc_adj;
  logic signed [PID_BITS-1:0]  pid;
  logic signed [SUM_BITS-1:0]  pid_ext;
  logic signed [SUM_BITS-1:0]  half_ext;
  logic signed [SUM_BITS-1:0]  sum_left;
  logic signed [SUM_BITS-1:0]  sum_right;

  function automatic logic signed [SPEED_BITS-1:0] clamp_speed(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] lim;
    lim = $signed(SUM_BITS'(SPEED_MAX));
    if (v > lim) begin
      return SPEED_FULL;
    end else if (v < -lim) begin
      return -SPEED_FULL;
    end else begin
      return v[SPEED_BITS-1:0];
    end
  endfunction

  assign diff    = {position[POSITION_BITS-1], position}
                 - {last_position[POSITION_BITS-1], last_position};
  assign prod_p  = ACC_BITS'($signed({1'b0, prop_gain})) * ACC_BITS'(position);
  assign prod_d  = ACC_BITS'($signed({1'b0, deriv_gain})) * ACC_BITS'(diff);
  assign acc     = prod_p + prod_d;
  // round toward zero on the divide by 16
  assign acc_adj = acc + {{(ACC_BITS-FRAC_BITS){1'b0}}, {FRAC_BITS{acc[ACC_BITS-1]}}};
  assign pid     = acc_adj[ACC_BITS-1:FRAC_BITS];

  assign pid_ext   = {pid[PID_BITS-1], pid};
  assign half_ext  = {{(SUM_BITS-SPEED_BITS){SPEED_HALF[SPEED_BITS-1]}}, SPEED_HALF};
  assign sum_left  = half_ext + pid_ext;
  assign sum_right = half_ext - pid_ext;

  assign left_speed  = clamp_speed(sum_left);
  assign right_speed = clamp_speed(sum_right);

endmodule

@@ rtl/smc_ctrl.sv @@
// ----------------------------------------------------------------------------
// smc_ctrl
// Mode machine, timers and held speeds; steps once per processed tick.
// ----------------------------------------------------------------------------
module smc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  smc_pkg::item_t   item,
  input  smc_pkg::cfg_t    cfg,
  output smc_pkg::result_t res
);
  import smc_pkg::*;

  logic [TIME_BITS-1:0]            now_ms;
  mode_t                           mode_reg;
  mode_t                           previous_mode;
  logic [TIME_BITS-1:0]            mode_start_time;
  logic [TIME_BITS-1:0]            strategy_start_time;
  logic [TIME_BITS-1:0]            follow_sample_time;
  logic signed [POSITION_BITS-1:0] last_position;
  logic                            step_phase;
  logic                            was_started;
  logic signed [SPEED_BITS-1:0]    left_hold;
  logic signed [SPEED_BITS-1:0]    right_hold;

  mode_t                           mode_next;
  mode_t                           previous_mode_next;
  logic [TIME_BITS-1:0]            mode_start_time_next;
  logic [TIME_BITS-1:0]            strategy_start_time_next;
  logic [TIME_BITS-1:0]            follow_sample_time_next;
  logic signed [POSITION_BITS-1:0] last_position_next;
  logic                            step_phase_next;
  logic signed [SPEED_BITS-1:0]    left_hold_next;
  logic signed [SPEED_BITS-1:0]    right_hold_next;
  logic                            fatal_next;

  logic signed [SPEED_BITS-1:0]    pd_left;
  logic signed [SPEED_BITS-1:0]    pd_right;

  smc_pd u_pd (
    .position      (item.target_position),
    .last_position (last_position),
    .prop_gain     (cfg.prop_gain),
    .deriv_gain    (cfg.deriv_gain),
    .left_speed    (pd_left),
    .right_speed   (pd_right)
  );

  always_comb begin
    logic [TIME_BITS-1:0] el;
    logic [TIME_BITS-1:0] turn_limit;
    mode_t                swap;
    mode_next                = mode_reg;
    previous_mode_next       = previous_mode;
    mode_start_time_next     = mode_start_time;
    strategy_start_time_next = strategy_start_time;
    follow_sample_time_next  = follow_sample_time;
    last_position_next       = last_position;
    step_phase_next          = step_phase;
    left_hold_next           = left_hold;
    right_hold_next          = right_hold;
    fatal_next               = 1'b0;
    el                       = '0;
    turn_limit               = TURN_RIGHT_MS;
    swap                     = MODE_OPENING;

    // restart on rising edge of started
    if (item.started && !was_started) begin
      previous_mode_next       = mode_next;
      mode_next                = MODE_OPENING;
      mode_start_time_next     = now_ms;
      strategy_start_time_next = now_ms;
    end

    if (item.started) begin
      if (mode_next != MODE_KEEPING && (item.line_left || item.line_right)) begin
        previous_mode_next   = mode_next;
        mode_next            = MODE_KEEPING;
        mode_start_time_next = now_ms;
      end
      el = now_ms - mode_start_time_next;
      unique case (mode_next)
        MODE_RUNNING: begin
          unique case (cfg.strategy)
            STRAT_STILL: begin
              left_hold_next  = SPEED_ZERO;
              right_hold_next = SPEED_ZERO;
            end
            STRAT_FOLLOW: begin
              if (now_ms - follow_sample_time > FOLLOW_MS) begin
                follow_sample_time_next = now_ms;
                last_position_next      = item.target_position;
                left_hold_next          = pd_left;
                right_hold_next         = pd_right;
              end
            end
            STRAT_STEPS: begin
              if (step_phase) begin
                if (now_ms - strategy_start_time_next > STEP_ON_MS) begin
                  left_hold_next           = SPEED_HALF;
                  right_hold_next          = SPEED_HALF;
                  step_phase_next          = 1'b0;
                  strategy_start_time_next = now_ms;
                end
              end else if (now_ms - strategy_start_time_next > STEP_OFF_MS) begin
                left_hold_next           = SPEED_ZERO;
                right_hold_next          = SPEED_ZERO;
                step_phase_next          = 1'b1;
                strategy_start_time_next = now_ms;
              end
            end
            default: begin
              fatal_next      = 1'b1;
              left_hold_next  = SPEED_ZERO;
              right_hold_next = SPEED_ZERO;
            end
          endcase
        end
        MODE_OPENING: begin
          unique case (cfg.opening_move)
            OPEN_FRONT: begin
              previous_mode_next   = mode_next;
              mode_next            = MODE_RUNNING;
              mode_start_time_next = now_ms;
            end
            OPEN_RIGHT, OPEN_LEFT, OPEN_BACK: begin
              if (cfg.opening_move == OPEN_LEFT) begin
                left_hold_next  = -SPEED_FULL;
                right_hold_next = SPEED_FULL;
                turn_limit      = TURN_LEFT_MS;
              end else begin
                left_hold_next  = SPEED_FULL;
                right_hold_next = -SPEED_FULL;
                turn_limit      = (cfg.opening_move == OPEN_BACK) ? TURN_BACK_MS
                                                                  : TURN_RIGHT_MS;
              end
              if (el > turn_limit) begin
                previous_mode_next   = mode_next;
                mode_next            = MODE_RUNNING;
                mode_start_time_next = now_ms;
              end
            end
            default: begin
              fatal_next      = 1'b1;
              left_hold_next  = SPEED_ZERO;
              right_hold_next = SPEED_ZERO;
            end
          endcase
        end
        MODE_KEEPING: begin
          if (el <= REVERSE_MS) begin
            left_hold_next  = -SPEED_FULL;
            right_hold_next = -SPEED_FULL;
          end else if (el <= SPIN_END_MS) begin
            left_hold_next  = SPEED_FULL;
            right_hold_next = -SPEED_FULL;
          end else begin
            swap                 = previous_mode_next;
            previous_mode_next   = mode_next;
            mode_next            = swap;
            mode_start_time_next = now_ms;
          end
        end
        default: begin
          fatal_next      = 1'b1;
          left_hold_next  = SPEED_ZERO;
          right_hold_next = SPEED_ZERO;
        end
      endcase
    end else begin
      left_hold_next  = SPEED_ZERO;
      right_hold_next = SPEED_ZERO;
    end
  end

  always_comb begin
    res.left_speed  = left_hold_next;
    res.right_speed = right_hold_next;
    res.mode        = mode_next;
    res.fatal_error = fatal_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms              <= '0;
      mode_reg            <= MODE_OPENING;
      previous_mode       <= MODE_OPENING;
      mode_start_time     <= '0;
      strategy_start_time <= '0;
      follow_sample_time  <= '0;
      last_position       <= '0;
      step_phase          <= 1'b0;
      was_started         <= 1'b0;
      left_hold           <= SPEED_ZERO;
      right_hold          <= SPEED_ZERO;
    end else if (step) begin
      now_ms              <= now_ms + 1'b1;
      mode_reg            <= mode_next;
      previous_mode       <= previous_mode_next;
      mode_start_time     <= mode_start_time_next;
      strategy_start_time <= strategy_start_time_next;
      follow_sample_time  <= follow_sample_time_next;
      last_position       <= last_position_next;
      step_phase          <= step_phase_next;
      was_started         <= item.started;
      left_hold           <= left_hold_next;
      right_hold          <= right_hold_next;
    end
  end

endmodule

@@ rtl/sumo_robot_maneuver_controller.sv @@
// ----------------------------------------------------------------------------
// sumo_robot_maneuver_controller
// Per-tick maneuver control: opening turn, strategy, keep-inside recovery.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  item    | item_valid / item_stall    | started, line_left, line_right,
//          |                            | target_position
//  result  | result_valid / result_stall| left_speed, right_speed, mode,
//          |                            | fatal_error
//  config  | cfg_write                  | cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; item register then
// result register, with the mode/timer/PD logic in between.
// Reset clears config to defaults, all controller state and both valids.
// A stalled result holds; item_stall rises only while the item register is
// full behind a stalled result.
// ----------------------------------------------------------------------------
module sumo_robot_maneuver_controller (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     item_valid,
  output logic                                     item_stall,
  input  logic                                     started,
  input  logic                                     line_left,
  input  logic                                     line_right,
  input  logic signed [smc_pkg::POSITION_BITS-1:0] target_position,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output logic signed [smc_pkg::SPEED_BITS-1:0]    left_speed,
  output logic signed [smc_pkg::SPEED_BITS-1:0]    right_speed,
  output logic [1:0]                               mode,
  output logic                                     fatal_error,
  input  logic                                     cfg_write,
  input  logic [1:0]                               cfg_index,
  input  logic [smc_pkg::GAIN_BITS-1:0]            cfg_data
);
  import smc_pkg::*;

  cfg_t    cfg;
  logic    held_valid;
  item_t   held_item;
  logic    accept;
  logic    advance;
  result_t res_next;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strategy     <= STRAT_STILL;
      cfg.opening_move <= OPEN_FRONT;
      cfg.prop_gain    <= 8'd16;
      cfg.deriv_gain   <= 8'd40;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STRATEGY: cfg.strategy     <= cfg_data[1:0];
        REG_OPENING:  cfg.opening_move <= cfg_data[2:0];
        REG_PROP:     cfg.prop_gain    <= cfg_data;
        REG_DERIV:    cfg.deriv_gain   <= cfg_data;
      endcase
    end
  end

  assign item_stall = held_valid && result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign advance    = held_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item.started         <= started;
      held_item.line_left       <= line_left;
      held_item.line_right      <= line_right;
      held_item.target_position <= target_position;
    end
  end

  smc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (held_item),
    .cfg  (cfg),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign left_speed  = res.left_speed;
  assign right_speed = res.right_speed;
  assign mode        = res.mode;
  assign fatal_error = res.fatal_error;

endmodule

@@ rtl/smc_checker.sv @@
// ----------------------------------------------------------------------------
// smc_checker
// Port-level checks of the maneuver controller, bound to the top level.
// ----------------------------------------------------------------------------
module smc_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     item_stall,
  input logic                                     result_valid,
  input logic                                     result_stall,
  input logic signed [smc_pkg::SPEED_BITS-1:0]    left_speed,
  input logic signed [smc_pkg::SPEED_BITS-1:0]    right_speed,
  input logic [1:0]                               mode,
  input logic                                     fatal_error
);
  import smc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable({left_speed, right_speed, mode, fatal_error}))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (left_speed <= SPEED_FULL && left_speed >= -SPEED_FULL
                      && right_speed <= SPEED_FULL && right_speed >= -SPEED_FULL))
    else $error("speed out of range");

  a_mode: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (mode <= MODE_KEEPING))
    else $error("unused mode code");

  a_fatal: assert property (@(posedge clk) disable iff (rst)
    result_valid && fatal_error |-> (left_speed == SPEED_ZERO && right_speed == SPEED_ZERO))
    else $error("fatal item without stop");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("outputs active after reset");

endmodule

bind sumo_robot_maneuver_controller smc_checker u_smc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .left_speed   (left_speed),
  .right_speed  (right_speed),
  .mode         (mode),
  .fatal_error  (fatal_error)
);

@@ verif/sumo_robot_maneuver_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sumo_robot_maneuver_controller_tb
// Self-checking bench for the sumo maneuver controller. A short directed table
// covers reset, every opening and strategy code, invalid codes, line hits and
// start edges; random start/line/position sequences then run under several
// register settings with random idling on both sides. Every tick is mirrored
// in a local controller model and each result is checked field by field.
// ----------------------------------------------------------------------------
module sumo_robot_maneuver_controller_tb;
  import smc_pkg::*;

  localparam int IDLE_LIMIT     = 4000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 4;

  logic                            clk             = 1'b0;
  logic                            rst             = 1'b1;
  logic                            item_valid      = 1'b0;
  logic                            item_stall;
  logic                            started         = 1'b0;
  logic                            line_left       = 1'b0;
  logic                            line_right      = 1'b0;
  logic signed [POSITION_BITS-1:0] target_position = '0;
  logic                            result_valid;
  logic                            result_stall    = 1'b1;
  logic signed [SPEED_BITS-1:0]    left_speed;
  logic signed [SPEED_BITS-1:0]    right_speed;
  logic [1:0]                      mode;
  logic                            fatal_error;
  logic                            cfg_write       = 1'b0;
  logic [1:0]                      cfg_index       = REG_STRATEGY;
  logic [GAIN_BITS-1:0]            cfg_data        = '0;

  // pinned result travelling with the item (directed rows)
  logic    pin_on  = 1'b0;
  result_t pin_cmd = '0;

  sumo_robot_maneuver_controller dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // controller model: registers and state
  logic [1:0]                      strategy_q;
  logic [2:0]                      opening_q;
  logic [GAIN_BITS-1:0]            prop_q, deriv_q;
  logic [TIME_BITS-1:0]            now_ms, mode_t0, strat_t0, sample_t0;
  mode_t                           mode_q, prior_mode;
  logic signed [POSITION_BITS-1:0] last_pos;
  logic                            step_on, was_started;
  logic signed [SPEED_BITS-1:0]    left_q, right_q;

  result_t due_cmds[$];
  int      sent_count    = 0;
  int      results_seen  = 0;
  int      mismatch_count = 0;
  int      idle_cycles   = 0;
  bit      calm_send     = 1'b0;
  bit      squeeze_req   = 1'b0;

  typedef struct {
    bit                              is_cfg;
    logic [1:0]                      strat;
    logic [2:0]                      opening;
    logic [GAIN_BITS-1:0]            pg, dg;
    logic                            st, ll, lr;
    logic signed [POSITION_BITS-1:0] pos;
    bit                              pin;
    result_t                         want;
  } drill_row_t;

  drill_row_t drill[$];

  function automatic void restore_defaults();
    strategy_q  = STRAT_STILL;
    opening_q   = OPEN_FRONT;
    prop_q      = 8'd16;
    deriv_q     = 8'd40;
    now_ms      = '0;
    mode_t0     = '0;
    strat_t0    = '0;
    sample_t0   = '0;
    mode_q      = MODE_OPENING;
    prior_mode  = MODE_OPENING;
    last_pos    = '0;
    step_on     = 1'b0;
    was_started = 1'b0;
    left_q      = SPEED_ZERO;
    right_q     = SPEED_ZERO;
  endfunction

  function automatic void shift_mode(input mode_t m);
    prior_mode = mode_q;
    mode_q     = m;
    mode_t0    = now_ms;
  endfunction

  function automatic void set_wheels(input logic signed [SPEED_BITS-1:0] l,
                                     input logic signed [SPEED_BITS-1:0] r);
    left_q  = l;
    right_q = r;
  endfunction

  function automatic void timed_turn(input logic signed [SPEED_BITS-1:0] l,
                                     input logic signed [SPEED_BITS-1:0] r,
                                     input logic [TIME_BITS-1:0] span);
    set_wheels(l, r);
    if (now_ms - mode_t0 > span) shift_mode(MODE_RUNNING);
  endfunction

  function automatic logic signed [SPEED_BITS-1:0] sat_speed(input int v);
    if (v > SPEED_MAX) return SPEED_FULL;
    if (v < -SPEED_MAX) return -SPEED_FULL;
    return v[SPEED_BITS-1:0];
  endfunction

  // one millisecond tick of the controller
  function automatic result_t advance_controller(input logic st, input logic hit,
                                                 input logic signed [POSITION_BITS-1:0] pos);
    result_t              r;
    logic                 fatal;
    logic [TIME_BITS-1:0] el;
    int                   p, pd;
    fatal = 1'b0;
    if (st && !was_started) begin
      shift_mode(MODE_OPENING);
      strat_t0 = now_ms;
    end
    was_started = st;
    if (st) begin
      if (mode_q != MODE_KEEPING && hit) shift_mode(MODE_KEEPING);
      case (mode_q)
        MODE_RUNNING: begin
          case (strategy_q)
            STRAT_STILL: set_wheels(SPEED_ZERO, SPEED_ZERO);
            STRAT_FOLLOW: begin
              if (now_ms - sample_t0 > FOLLOW_MS) begin
                p  = int'(pos);
                pd = (int'(prop_q) * p + int'(deriv_q) * (p - int'(last_pos)))
                     / (1 << FRAC_BITS);
                sample_t0 = now_ms;
                last_pos  = pos;
                set_wheels(sat_speed(int'(SPEED_HALF) + pd), sat_speed(int'(SPEED_HALF) - pd));
              end
            end
            STRAT_STEPS: begin
              el = now_ms - strat_t0;
              if (step_on) begin
                if (el > STEP_ON_MS) begin
                  set_wheels(SPEED_HALF, SPEED_HALF);
                  step_on  = 1'b0;
                  strat_t0 = now_ms;
                end
              end else if (el > STEP_OFF_MS) begin
                set_wheels(SPEED_ZERO, SPEED_ZERO);
                step_on  = 1'b1;
                strat_t0 = now_ms;
              end
            end
            default: begin
              fatal = 1'b1;
              set_wheels(SPEED_ZERO, SPEED_ZERO);
            end
          endcase
        end
        MODE_OPENING: begin
          case (opening_q)
            OPEN_FRONT: shift_mode(MODE_RUNNING);
            OPEN_RIGHT: timed_turn(SPEED_FULL, -SPEED_FULL, TURN_RIGHT_MS);
            OPEN_LEFT:  timed_turn(-SPEED_FULL, SPEED_FULL, TURN_LEFT_MS);
            OPEN_BACK:  timed_turn(SPEED_FULL, -SPEED_FULL, TURN_BACK_MS);
            default: begin
              fatal = 1'b1;
              set_wheels(SPEED_ZERO, SPEED_ZERO);
            end
          endcase
        end
        MODE_KEEPING: begin
          el = now_ms - mode_t0;
          if (el <= REVERSE_MS) set_wheels(-SPEED_FULL, -SPEED_FULL);
          else if (el <= SPIN_END_MS) set_wheels(SPEED_FULL, -SPEED_FULL);
          else shift_mode(prior_mode);
        end
        default: begin
          fatal = 1'b1;
          set_wheels(SPEED_ZERO, SPEED_ZERO);
        end
      endcase
    end else begin
      set_wheels(SPEED_ZERO, SPEED_ZERO);
    end
    now_ms = now_ms + 1'b1;
    r.left_speed  = left_q;
    r.right_speed = right_q;
    r.mode        = mode_q;
    r.fatal_error = fatal;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // port monitor: config mirror, result check, item mirror, watchdog
  always @(posedge clk) begin : port_watch
    result_t want;
    result_t fresh;
    bit      moved;
    moved = 1'b0;
    if (rst) begin
      restore_defaults();
      due_cmds.delete();
      idle_cycles = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STRATEGY: strategy_q = cfg_data[1:0];
          REG_OPENING:  opening_q  = cfg_data[2:0];
          REG_PROP:     prop_q     = cfg_data;
          REG_DERIV:    deriv_q    = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        results_seen++;
        if (due_cmds.size() == 0) begin
          flag_mismatch($sformatf("result %0d with no item pending", results_seen));
        end else begin
          want = due_cmds.pop_front();
          if (left_speed !== want.left_speed)
            flag_mismatch($sformatf("result %0d left_speed %0d, want %0d",
                                    results_seen, left_speed, want.left_speed));
          if (right_speed !== want.right_speed)
            flag_mismatch($sformatf("result %0d right_speed %0d, want %0d",
                                    results_seen, right_speed, want.right_speed));
          if (mode !== want.mode)
            flag_mismatch($sformatf("result %0d mode %0d, want %0d",
                                    results_seen, mode, want.mode));
          if (fatal_error !== want.fatal_error)
            flag_mismatch($sformatf("result %0d fatal_error %0b, want %0b",
                                    results_seen, fatal_error, want.fatal_error));
        end
      end
      if (item_valid && !item_stall) begin
        moved = 1'b1;
        fresh = advance_controller(started, line_left | line_right, target_position);
        due_cmds.push_back(pin_on ? pin_cmd : fresh);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [POSITION_BITS-1:0] pick_position();
    logic signed [POSITION_BITS-1:0] v;
    v = POSITION_BITS'($urandom);
    case ($urandom_range(0, 15))
      0: v = {1'b0, {(POSITION_BITS-1){1'b1}}};
      1: v = {1'b1, {(POSITION_BITS-1){1'b0}}};
      2: v = '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin : result_side
    int run, stall_len, k;
    forever begin
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      result_stall <= 1'b0;
      k = 0;
      do begin
        @(posedge clk);
        k++;
      end while (k < run && !squeeze_req);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_len = SQUEEZE_CYCLES;
      end else begin
        stall_len = pick_gap();
        if (stall_len == 0) stall_len = 1;
      end
      result_stall <= 1'b1;
      repeat (stall_len) @(posedge clk);
    end
  end

  task automatic send_tick(input logic st, input logic ll, input logic lr,
                           input logic signed [POSITION_BITS-1:0] pos,
                           input bit pin, input result_t want);
    int gap;
    bit taken;
    gap = calm_send ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid      <= 1'b1;
    started         <= st;
    line_left       <= ll;
    line_right      <= lr;
    target_position <= pos;
    pin_on          <= pin;
    pin_cmd         <= want;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end
    sent_count++;
  endtask

  task automatic wait_drained();
    while (results_seen != sent_count) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [1:0] strat, input logic [2:0] opening,
                          input logic [GAIN_BITS-1:0] pg, input logic [GAIN_BITS-1:0] dg);
    item_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_STRATEGY;
    cfg_data  <= GAIN_BITS'(strat);
    @(posedge clk);
    cfg_index <= REG_OPENING;
    cfg_data  <= GAIN_BITS'(opening);
    @(posedge clk);
    cfg_index <= REG_PROP;
    cfg_data  <= pg;
    @(posedge clk);
    cfg_index <= REG_DERIV;
    cfg_data  <= dg;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // start/line/position run; noisy runs drop the start flag now and then
  task automatic run_bout(input int span, input int line_odds, input bit noisy);
    int   k;
    logic st, ll, lr;
    repeat ($urandom_range(1, 3))
      send_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                pick_position(), 1'b0, '0);
    for (k = 0; k < span; k++) begin
      st = !(noisy && $urandom_range(0, 199) == 0);
      ll = (line_odds != 0) && ($urandom_range(1, line_odds) == 1);
      lr = (line_odds != 0) && ($urandom_range(1, line_odds) == 1);
      send_tick(st, ll, lr, pick_position(), 1'b0, '0);
    end
  endtask

  function automatic void put_cfg(input logic [1:0] strat, input logic [2:0] opening,
                                  input logic [GAIN_BITS-1:0] pg,
                                  input logic [GAIN_BITS-1:0] dg);
    drill_row_t row;
    row.is_cfg  = 1'b1;
    row.strat   = strat;
    row.opening = opening;
    row.pg      = pg;
    row.dg      = dg;
    drill.push_back(row);
  endfunction

  function automatic void put_tick(input logic st, input logic ll, input logic lr,
                                   input logic signed [POSITION_BITS-1:0] pos, input bit pin,
                                   input logic signed [SPEED_BITS-1:0] l,
                                   input logic signed [SPEED_BITS-1:0] r,
                                   input mode_t m, input logic f);
    drill_row_t row;
    row.is_cfg           = 1'b0;
    row.st               = st;
    row.ll               = ll;
    row.lr               = lr;
    row.pos              = pos;
    row.pin              = pin;
    row.want.left_speed  = l;
    row.want.right_speed = r;
    row.want.mode        = m;
    row.want.fatal_error = f;
    drill.push_back(row);
  endfunction

  initial begin : stimulus
    int ph, goal, odds;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    put_tick(1'b0, 1'b0, 1'b0, 11'h000, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_OPENING, 1'b0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h3FF, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_RUNNING, 1'b0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h400, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_RUNNING, 1'b0);
    put_tick(1'b1, 1'b1, 1'b0, 11'h7FF, 1'b1, -SPEED_FULL, -SPEED_FULL, MODE_KEEPING, 1'b0);
    put_tick(1'b1, 1'b1, 1'b1, 11'h000, 1'b1, -SPEED_FULL, -SPEED_FULL, MODE_KEEPING, 1'b0);
    put_tick(1'b0, 1'b1, 1'b1, 11'h000, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_KEEPING, 1'b0);
    put_cfg(2'd3, OPEN_FRONT, 8'd16, 8'd40);
    put_tick(1'b1, 1'b0, 1'b0, 11'h200, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_RUNNING, 1'b0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h600, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_RUNNING, 1'b1);
    put_cfg(STRAT_FOLLOW, 3'd7, 8'd255, 8'd255);
    put_tick(1'b0, 1'b0, 1'b0, 11'h155, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_RUNNING, 1'b0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h2AA, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_OPENING, 1'b1);
    put_cfg(STRAT_FOLLOW, 3'd4, 8'd0, 8'd0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h064, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_OPENING, 1'b1);
    put_cfg(STRAT_STILL, OPEN_RIGHT, 8'd16, 8'd40);
    put_tick(1'b1, 1'b0, 1'b0, 11'h000, 1'b1, SPEED_FULL, -SPEED_FULL, MODE_OPENING, 1'b0);
    put_tick(1'b1, 1'b1, 1'b0, 11'h000, 1'b1, -SPEED_FULL, -SPEED_FULL, MODE_KEEPING, 1'b0);
    put_cfg(STRAT_STILL, OPEN_LEFT, 8'd16, 8'd40);
    put_tick(1'b0, 1'b0, 1'b1, 11'h000, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_KEEPING, 1'b0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h000, 1'b1, -SPEED_FULL, SPEED_FULL, MODE_OPENING, 1'b0);
    put_cfg(STRAT_STILL, OPEN_BACK, 8'd16, 8'd40);
    put_tick(1'b1, 1'b0, 1'b0, 11'h7FF, 1'b1, SPEED_FULL, -SPEED_FULL, MODE_OPENING, 1'b0);
    put_cfg(STRAT_FOLLOW, OPEN_FRONT, 8'd255, 8'd255);
    put_tick(1'b0, 1'b0, 1'b0, 11'h000, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_OPENING, 1'b0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h3FF, 1'b1, SPEED_ZERO, SPEED_ZERO, MODE_RUNNING, 1'b0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h400, 1'b0, SPEED_ZERO, SPEED_ZERO, MODE_OPENING, 1'b0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h3FF, 1'b0, SPEED_ZERO, SPEED_ZERO, MODE_OPENING, 1'b0);
    put_cfg(STRAT_STEPS, OPEN_FRONT, 8'd16, 8'd40);
    put_tick(1'b1, 1'b0, 1'b0, 11'h000, 1'b0, SPEED_ZERO, SPEED_ZERO, MODE_OPENING, 1'b0);
    put_tick(1'b1, 1'b0, 1'b0, 11'h123, 1'b0, SPEED_ZERO, SPEED_ZERO, MODE_OPENING, 1'b0);

    foreach (drill[i]) begin
      if (drill[i].is_cfg)
        set_regs(drill[i].strat, drill[i].opening, drill[i].pg, drill[i].dg);
      else
        send_tick(drill[i].st, drill[i].ll, drill[i].lr, drill[i].pos,
                  drill[i].pin, drill[i].want);
    end

    // random phases under changing register settings
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(STRAT_FOLLOW, OPEN_RIGHT, 8'd255, 8'd255);
        1: set_regs(STRAT_FOLLOW, OPEN_FRONT, 8'd0, 8'd0);
        2: set_regs(STRAT_STEPS, OPEN_LEFT, 8'd16, 8'd40);
        default: set_regs(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                          pick_gain(), pick_gain());
      endcase
      if (ph == 2) squeeze_req = 1'b1;
      goal = sent_count + 120;
      while (sent_count < goal) begin
        calm_send = (ph == 2) || ($urandom_range(0, 3) == 0);
        odds = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 60 : 400);
        run_bout($urandom_range(20, 150), odds, 1'b1);
      end
    end

    item_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/smc_pkg.sv
rtl/smc_pd.sv
rtl/smc_ctrl.sv
rtl/sumo_robot_maneuver_controller.sv
rtl/smc_checker.sv
verif/sumo_robot_maneuver_controller_tb.sv
